>>> rtl/dq_pkg.sv
package dq_pkg;

	// Default sizes of the store.
	localparam int DEPTH_DEF      = 256;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed widths of the transaction fields.
	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd5;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;     // take the incoming transaction into the operation register
		logic execute;     // perform the held operation
		logic finish_read; // registered store word is ready, complete the result
	} dq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;  // held operation is a read that will access the store
		logic out_free; // output register is empty or being emptied this cycle
	} dq_stat_t;

endpackage

>>> rtl/dq_ctrl.sv
module dq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  dq_pkg::dq_stat_t  stat,
	output dq_pkg::dq_cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		cmd.capture      = 1'b0;
		cmd.execute      = 1'b0;
		cmd.finish_read  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// Wait here until the previous result has left the output register.
				if (stat.out_free) begin
					cmd.execute = 1'b1;
					state_d     = stat.is_read ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.finish_read = 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/dq_datapath.sv
module dq_datapath #(
	parameter int DEPTH      = dq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [dq_pkg::FUNC_W-1:0]           in_func,
	input  logic signed [dq_pkg::VALUE_W-1:0]   in_value,
	input  logic [dq_pkg::POS_W-1:0]            in_position,
	input  dq_pkg::dq_cmd_t                     cmd,
	output dq_pkg::dq_stat_t                    stat,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dq_pkg::VALUE_W-1:0]   out_data,
	output logic [dq_pkg::STATUS_W-1:0]         out_status,
	output logic [dq_pkg::COUNT_W-1:0]          out_count,
	output logic                                out_is_empty,
	output logic                                out_is_full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;

	localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] HELD_FULL = CW'(DEPTH);
	localparam logic [PW:0]   SUM_WRAP  = (PW + 1)'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] held_q;

	logic [dq_pkg::FUNC_W-1:0] func_q;
	logic [DATA_WIDTH-1:0]     word_q;
	logic [PW-1:0]             off_q;

	logic [PW-1:0] head_d, tail_d;
	logic [CW-1:0] held_d;
	logic [dq_pkg::STATUS_W-1:0] status_d;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic          rd_go;

	logic [XW-1:0] pos_x, held_x, off_x;
	logic [PW:0]   rd_sum;
	logic [PW-1:0] rd_addr;
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic signed [DATA_WIDTH-1:0] rd_signed;

	logic out_valid_q;
	logic signed [dq_pkg::VALUE_W-1:0] data_q;
	logic [dq_pkg::STATUS_W-1:0]       status_q;
	logic [dq_pkg::COUNT_W-1:0]        count_q;
	logic empty_q, full_q;

	logic held_is_full, held_is_empty;

	function automatic logic [PW-1:0] ptr_up(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_down(input logic [PW-1:0] p);
		return (p == '0) ? PTR_LAST : p - 1'b1;
	endfunction

	assign held_is_full  = (held_q == HELD_FULL);
	assign held_is_empty = (held_q == '0);

	// Read position is clamped to the last element while taking the transaction.
	assign pos_x  = XW'(in_position);
	assign held_x = XW'(held_q);
	assign off_x  = (pos_x >= held_x) ? held_x - 1'b1 : pos_x;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_func;
			word_q <= DATA_WIDTH'($unsigned(in_value));
			off_q  <= PW'(off_x);
		end
	end

	assign rd_sum  = (PW + 1)'(head_q) + (PW + 1)'(off_q);
	assign rd_addr = (rd_sum >= SUM_WRAP) ? PW'(rd_sum - SUM_WRAP) : PW'(rd_sum);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		held_d   = held_q;
		status_d = dq_pkg::STATUS_DONE;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		rd_go    = 1'b0;
		case (func_q)
			dq_pkg::FUNC_PUSH_BACK: begin
				if (held_is_full) begin
					status_d = dq_pkg::STATUS_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = tail_q;
					tail_d  = ptr_up(tail_q);
					held_d  = held_q + 1'b1;
				end
			end
			dq_pkg::FUNC_PUSH_FRONT: begin
				if (held_is_full) begin
					status_d = dq_pkg::STATUS_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = ptr_down(head_q);
					head_d  = ptr_down(head_q);
					held_d  = held_q + 1'b1;
				end
			end
			dq_pkg::FUNC_POP_FRONT: begin
				if (held_is_empty) begin
					status_d = dq_pkg::STATUS_EMPTY;
				end else begin
					head_d = ptr_up(head_q);
					held_d = held_q - 1'b1;
				end
			end
			dq_pkg::FUNC_POP_BACK: begin
				if (held_is_empty) begin
					status_d = dq_pkg::STATUS_EMPTY;
				end else begin
					tail_d = ptr_down(tail_q);
					held_d = held_q - 1'b1;
				end
			end
			dq_pkg::FUNC_READ: begin
				if (held_is_empty) begin
					status_d = dq_pkg::STATUS_EMPTY;
				end else begin
					rd_go = 1'b1;
				end
			end
			dq_pkg::FUNC_CLEAR: begin
				head_d = '0;
				tail_d = '0;
				held_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign stat.is_read  = rd_go;
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			held_q <= '0;
		end else if (cmd.execute) begin
			head_q <= head_d;
			tail_q <= tail_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && wr_en) begin
			mem[wr_addr] <= word_q;
		end
		if (cmd.execute && rd_go) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_signed = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.execute && !rd_go) || cmd.finish_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q <= status_d;
			count_q  <= dq_pkg::COUNT_W'(held_d);
			empty_q  <= (held_d == '0);
			full_q   <= (held_d == HELD_FULL);
			data_q   <= '0;
		end
		if (cmd.finish_read) begin
			data_q <= dq_pkg::VALUE_W'(rd_signed);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = data_q;
	assign out_status   = status_q;
	assign out_count    = count_q;
	assign out_is_empty = empty_q;
	assign out_is_full  = full_q;

endmodule

>>> rtl/double_ended_queue.sv
// Channel  | Direction | tdata (lowest bit first)                         | tuser
// ---------+-----------+--------------------------------------------------+------------
// s_axis   | in        | value[31:0], position[39:32]                      | func[2:0]
// m_axis   | out       | data[31:0], status[33:32], count[42:34],          | none
//          |           | is_empty[43], is_full[44], zero fill to bit 47    |
//
// Each operation is taken in the idle state and carried out on the pointers, the
// count and the store in the execute state, which waits for a free output register.
// A read adds a read state, set by the registered read port of the store memory.
// Reset clears the pointers, the count, the controller and the output valid; the
// store keeps its contents, and only entries written since are ever read.
// A new transaction is taken while a result still waits on the master side; it
// is then held until the output register frees.
module double_ended_queue #(
	parameter int DEPTH      = dq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // value[31:0], position[39:32]
	input  logic [2:0]  s_tuser,  // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // data, status, count, is_empty, is_full, zero fill
);

	dq_pkg::dq_cmd_t  cmd;
	dq_pkg::dq_stat_t stat;

	logic signed [dq_pkg::VALUE_W-1:0] out_data;
	logic [dq_pkg::STATUS_W-1:0]       out_status;
	logic [dq_pkg::COUNT_W-1:0]        out_count;
	logic                              out_is_empty;
	logic                              out_is_full;

	// The controller sequences each transaction through capture, execute and,
	// for reads, the memory read cycle.
	dq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the pointers, the count, the store and the output register.
	dq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_func      (s_tuser),
		.in_value     (s_tdata[31:0]),
		.in_position  (s_tdata[39:32]),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_data     (out_data),
		.out_status   (out_status),
		.out_count    (out_count),
		.out_is_empty (out_is_empty),
		.out_is_full  (out_is_full)
	);

	// Result fields are packed from bit zero up, with zeros filling the top three bits.
	assign m_tdata = {3'b000, out_is_full, out_is_empty, out_count, out_status, out_data};

endmodule
